// File: rtl/ukh_pkg.sv
package ukh_pkg;

    localparam int MAX_FIELD_DEF = 1024;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SHARD_W  = 15;
    localparam int LEN_W    = 11;
    localparam int COUNT_W  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam int HASH_SHIFT = 16;
    localparam logic [COUNT_W-1:0] DIGIT_LIMIT = 16'd10000;
    localparam int DIV_STEPS = SHARD_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic [CFG_ADDR_W-1:0] REG_REWRITE_ENABLE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHARD_COUNT    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_REWRITTEN = 2'd0,
        STATUS_DECLINED  = 2'd1,
        STATUS_ERROR     = 2'd2
    } status_t;

    typedef struct packed {
        logic take_byte;
        logic finish_uri;
        logic div_step;
        logic load_result;
    } ukh_cmd_t;

    typedef struct packed {
        logic div_last;
    } ukh_stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [BYTE_W-1:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/ukh_ctrl.sv
module ukh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ukh_pkg::ukh_cmd_t cmd,
    input  ukh_pkg::ukh_stat_t stat
);

    typedef enum logic [1:0] {
        ST_PARSE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_PARSE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmd.take_byte   = accept;
        cmd.finish_uri  = accept && s_tlast;
        cmd.div_step    = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_PARSE: begin
                if (accept && s_tlast) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // wait for the result slot to drain
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_PARSE;
                end
            end
            default: begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_PARSE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_finish_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_uri |=> state_reg == ST_DIV)
        else $error("last request did not start the divider");
    a_div_ends_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && stat.div_last) |=> state_reg == ST_HOLD)
        else $error("divider end did not reach hold");
    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> m_tvalid)
        else $error("loaded result not presented");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");
`endif

endmodule

// File: rtl/ukh_datapath.sv
module ukh_datapath #(
    parameter int MAX_FIELD = ukh_pkg::MAX_FIELD_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ukh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ukh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [ukh_pkg::BYTE_W-1:0]        uri_byte,
    input  ukh_pkg::ukh_cmd_t                 cmd,
    output ukh_pkg::ukh_stat_t                stat,
    output logic [ukh_pkg::STATUS_W-1:0]      status,
    output logic [ukh_pkg::SHARD_W-1:0]       shard_index,
    output logic [ukh_pkg::LEN_W-1:0]         key_length,
    output logic [ukh_pkg::LEN_W-1:0]         db_length
);

    localparam int CNT_W = $clog2(MAX_FIELD + 1);
    localparam logic [CNT_W-1:0] FIELD_MAX = CNT_W'(MAX_FIELD);

    typedef enum logic [2:0] {
        PH_SLASH,
        PH_DB,
        PH_KEY0,
        PH_KEY,
        PH_REST,
        PH_BAD
    } phase_t;

    logic                            enable_reg;
    logic [ukh_pkg::COUNT_W-1:0]     shard_count_reg;

    phase_t             phase_reg, phase_next;
    logic [31:0]        crc_reg, crc_next;
    logic [CNT_W-1:0]   db_cnt_reg, db_cnt_next;
    logic [CNT_W-1:0]   key_cnt_reg, key_cnt_next;
    logic               ended_reg, ended_next;
    logic [CNT_W-1:0]   key_inc;
    logic               hashable;

    logic [ukh_pkg::SHARD_W-1:0]  hash_reg;
    logic [ukh_pkg::COUNT_W-1:0]  divisor_reg;
    logic [ukh_pkg::COUNT_W-1:0]  rem_reg, rem_next;
    logic [ukh_pkg::STEP_W-1:0]   step_reg;
    logic                         decline_reg;
    logic [ukh_pkg::LEN_W-1:0]    klen_reg;
    logic [ukh_pkg::LEN_W-1:0]    dlen_reg;
    logic [ukh_pkg::COUNT_W:0]    trial;

    logic [ukh_pkg::STATUS_W-1:0] status_reg;
    logic [ukh_pkg::SHARD_W-1:0]  shard_reg;
    logic [ukh_pkg::LEN_W-1:0]    klen_out_reg;
    logic [ukh_pkg::LEN_W-1:0]    dlen_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            shard_count_reg <= ukh_pkg::COUNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ukh_pkg::REG_REWRITE_ENABLE: enable_reg      <= cfg_wdata[0];
                ukh_pkg::REG_SHARD_COUNT:    shard_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_inc = key_cnt_reg + CNT_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        db_cnt_next  = db_cnt_reg;
        key_cnt_next = key_cnt_reg;
        ended_next   = ended_reg;
        if (!ended_reg) begin
            if (uri_byte == ukh_pkg::CH_NUL) begin
                ended_next = 1'b1;
            end else begin
                case (phase_reg)
                    PH_SLASH: begin
                        phase_next = (uri_byte == ukh_pkg::CH_SLASH) ? PH_DB : PH_BAD;
                    end
                    PH_DB: begin
                        if (uri_byte == ukh_pkg::CH_SLASH) begin
                            phase_next = (db_cnt_reg != '0) ? PH_KEY0 : PH_BAD;
                        end else if (db_cnt_reg < FIELD_MAX) begin
                            db_cnt_next = db_cnt_reg + CNT_W'(1);
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_KEY0, PH_KEY: begin
                        if (uri_byte == ukh_pkg::CH_QUERY || uri_byte == ukh_pkg::CH_SLASH) begin
                            phase_next = (key_cnt_reg != '0) ? PH_REST : PH_BAD;
                        end else begin
                            crc_next     = ukh_pkg::crc_byte(crc_reg, uri_byte);
                            key_cnt_next = key_inc;
                            // stop hashing once the key reaches its size limit
                            phase_next   = (key_inc >= FIELD_MAX) ? PH_REST : PH_KEY;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign hashable = enable_reg && (phase_next == PH_KEY || phase_next == PH_REST)
                      && (key_cnt_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SLASH;
            crc_reg     <= ukh_pkg::CRC_INIT;
            db_cnt_reg  <= '0;
            key_cnt_reg <= '0;
            ended_reg   <= 1'b0;
        end else if (cmd.finish_uri) begin
            phase_reg   <= PH_SLASH;
            crc_reg     <= ukh_pkg::CRC_INIT;
            db_cnt_reg  <= '0;
            key_cnt_reg <= '0;
            ended_reg   <= 1'b0;
        end else if (cmd.take_byte) begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            db_cnt_reg  <= db_cnt_next;
            key_cnt_reg <= key_cnt_next;
            ended_reg   <= ended_next;
        end
    end

    // one restoring division step per cycle, hash bits MSB first
    assign trial = {rem_reg, hash_reg[ukh_pkg::SHARD_W-1]};

    always_comb begin
        if (trial >= {1'b0, divisor_reg}) begin
            rem_next = ukh_pkg::COUNT_W'(trial - {1'b0, divisor_reg});
        end else begin
            rem_next = trial[ukh_pkg::COUNT_W-1:0];
        end
    end

    assign stat.div_last = (step_reg == ukh_pkg::STEP_W'(ukh_pkg::DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.finish_uri) begin
            hash_reg    <= ukh_pkg::SHARD_W'(~crc_next >> ukh_pkg::HASH_SHIFT);
            divisor_reg <= (shard_count_reg == '0) ? ukh_pkg::COUNT_W'(1) : shard_count_reg;
            rem_reg     <= '0;
            step_reg    <= '0;
            decline_reg <= !hashable;
            klen_reg    <= enable_reg ? ukh_pkg::LEN_W'(key_cnt_next) : '0;
            dlen_reg    <= enable_reg ? ukh_pkg::LEN_W'(db_cnt_next) : '0;
        end else if (cmd.div_step) begin
            hash_reg <= hash_reg << 1;
            rem_reg  <= rem_next;
            step_reg <= step_reg + ukh_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            if (decline_reg) begin
                status_reg <= ukh_pkg::STATUS_DECLINED;
                shard_reg  <= '0;
            end else begin
                status_reg <= (rem_reg >= ukh_pkg::DIGIT_LIMIT) ? ukh_pkg::STATUS_ERROR
                                                                : ukh_pkg::STATUS_REWRITTEN;
                shard_reg  <= rem_reg[ukh_pkg::SHARD_W-1:0];
            end
            klen_out_reg <= klen_reg;
            dlen_out_reg <= dlen_reg;
        end
    end

    assign status      = status_reg;
    assign shard_index = shard_reg;
    assign key_length  = klen_out_reg;
    assign db_length   = dlen_out_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < divisor_reg))
        else $error("division remainder out of range");
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (divisor_reg != '0))
        else $error("zero divisor in divider");
`endif

endmodule

// File: rtl/uri_key_shard_hash.sv
// Shard selection for request URIs of the form /db/key[rest].
// Input stream: one URI byte per request on s_tdata, s_tlast on the final
// byte. A zero byte ends the string; later bytes up to s_tlast are ignored.
// Result stream: one result per URI, produced after the s_tlast byte:
// status, shard_index = ((crc32(key) >> 16) & 0x7fff) mod shard_count,
// and the key and database byte counts.
// Throughput: one byte per cycle while a URI is being parsed. After the
// last byte the input stalls while the bit-serial shard remainder unit
// runs and until the result is loaded into the output register, which
// waits for that register to be free.
// The output register decouples the sides: bytes of the next URI are
// taken while a result waits; only its final result waits for m_tready.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata, index 0 rewrite_enable,
// index 1 shard_count; write only while idle.
// Reset (aresetn low, synchronous) clears the parser, drops any pending
// result and sets rewrite_enable = 0, shard_count = 1.
module uri_key_shard_hash #(
    parameter int MAX_FIELD = ukh_pkg::MAX_FIELD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ukh_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ukh_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ukh_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] uri_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [16:2] shard_index, [27:17] key_length,
    // [38:28] db_length, [39] zero
    output logic [ukh_pkg::M_DATA_W-1:0]   m_tdata
);

    ukh_pkg::ukh_cmd_t            cmd;
    ukh_pkg::ukh_stat_t           stat;
    logic [ukh_pkg::STATUS_W-1:0] status;
    logic [ukh_pkg::SHARD_W-1:0]  shard_index;
    logic [ukh_pkg::LEN_W-1:0]    key_length;
    logic [ukh_pkg::LEN_W-1:0]    db_length;

    ukh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ukh_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .uri_byte    (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .shard_index (shard_index),
        .key_length  (key_length),
        .db_length   (db_length)
    );

    assign m_tdata = {1'b0, db_length, key_length, shard_index, status};

endmodule

// File: tb/tb.sv
module tb;
    import ukh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum logic [2:0] {
        PH_LEAD, PH_DBNAME, PH_KEYSTART, PH_KEYBODY, PH_TAIL, PH_BROKEN
    } parse_ph_t;

    // lowest field last: status sits in the low bits
    typedef struct packed {
        logic [LEN_W-1:0]   db_len;
        logic [LEN_W-1:0]   key_len;
        logic [SHARD_W-1:0] shard;
        status_t            status;
    } shard_result_t;

    class uri_shard_checker;
        bit                 rw_en;
        logic [15:0]        shard_div;
        parse_ph_t          ph;
        logic [31:0]        crc;
        int                 db_cnt;
        int                 key_cnt;
        bit                 ended;
        shard_result_t      shard_due[$];
        int                 mismatches;
        int                 results_seen;
        int                 status_hits[3];

        function new();
            rw_en = 1'b0;
            shard_div = 16'd1;
            clear_parse();
        endfunction

        function void clear_parse();
            ph = PH_LEAD;
            crc = 32'hFFFF_FFFF;
            db_cnt = 0;
            key_cnt = 0;
            ended = 1'b0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
            if (addr == REG_REWRITE_ENABLE) begin
                rw_en = val[0];
            end else begin
                shard_div = val;
            end
        endfunction

        function logic [31:0] crc32_shift(logic [31:0] c, logic [7:0] b);
            logic fb;
            c[7:0] = c[7:0] ^ b;
            for (int i = 0; i < 8; i++) begin
                fb = c[0];
                c = {1'b0, c[31:1]};
                if (fb) begin
                    c = c ^ 32'hEDB8_8320;
                end
            end
            return c;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", what);
            end
        endfunction

        // advance the parser by one URI byte; queue a result on the last byte
        function void take_uri_byte(logic [7:0] b, logic last);
            shard_result_t r;
            int unsigned   hash;
            int unsigned   div;
            int unsigned   shard;
            if (!ended) begin
                if (b == CH_NUL) begin
                    ended = 1'b1;
                end else begin
                    case (ph)
                        PH_LEAD: begin
                            ph = (b == CH_SLASH) ? PH_DBNAME : PH_BROKEN;
                        end
                        PH_DBNAME: begin
                            if (b == CH_SLASH) begin
                                ph = (db_cnt > 0) ? PH_KEYSTART : PH_BROKEN;
                            end else if (db_cnt < MAX_FIELD_DEF) begin
                                db_cnt++;
                            end else begin
                                ph = PH_BROKEN;
                            end
                        end
                        PH_KEYSTART, PH_KEYBODY: begin
                            if (b == CH_QUERY || b == CH_SLASH) begin
                                ph = (key_cnt > 0) ? PH_TAIL : PH_BROKEN;
                            end else begin
                                crc = crc32_shift(crc, b);
                                key_cnt++;
                                ph = (key_cnt >= MAX_FIELD_DEF) ? PH_TAIL : PH_KEYBODY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (last) begin
                r.shard = '0;
                r.key_len = key_cnt[LEN_W-1:0];
                r.db_len = db_cnt[LEN_W-1:0];
                if (!rw_en) begin
                    r.status = STATUS_DECLINED;
                    r.key_len = '0;
                    r.db_len = '0;
                end else if ((ph == PH_KEYBODY || ph == PH_TAIL) && key_cnt > 0) begin
                    hash = (~crc >> HASH_SHIFT) & 32'h7FFF;
                    div = (shard_div == 0) ? 1 : shard_div;
                    shard = hash % div;
                    r.shard = shard[SHARD_W-1:0];
                    r.status = (shard >= 10000) ? STATUS_ERROR : STATUS_REWRITTEN;
                end else begin
                    r.status = STATUS_DECLINED;
                end
                shard_due.push_back(r);
                clear_parse();
            end
        endfunction

        function void match_result(logic [M_DATA_W-1:0] d);
            shard_result_t got;
            shard_result_t want;
            got = shard_result_t'(d[$bits(shard_result_t)-1:0]);
            results_seen++;
            if (shard_due.size() == 0) begin
                flag($sformatf("unexpected result: status %0d shard %0d key_len %0d db_len %0d",
                               got.status, got.shard, got.key_len, got.db_len));
            end else begin
                want = shard_due.pop_front();
                if (want.status <= STATUS_ERROR) begin
                    status_hits[want.status]++;
                end
                if (got.status !== want.status || got.shard !== want.shard ||
                    got.key_len !== want.key_len || got.db_len !== want.db_len) begin
                    flag($sformatf({"result %0d mismatch: expected status %0d shard %0d ",
                                    "key_len %0d db_len %0d, got status %0d shard %0d ",
                                    "key_len %0d db_len %0d"},
                                   results_seen, want.status, want.shard, want.key_len,
                                   want.db_len, got.status, got.shard, got.key_len,
                                   got.db_len));
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    uri_shard_checker board;
    logic [7:0]       uri_bytes[$];
    int               send_idle_pct;
    int               recv_idle_pct;
    int               cycles;
    int               uris_sent;
    int               bytes_sent;

    uri_key_shard_hash u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #5 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.shard_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.match_result(m_tdata);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        board.take_uri_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_uri();
        for (int i = 0; i < uri_bytes.size(); i++) begin
            send_byte(uri_bytes[i], i == uri_bytes.size() - 1);
        end
        uris_sent++;
        uri_bytes.delete();
    endtask

    // hold the input until every queued result is out, then let the pipe settle
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (board.shard_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.write_reg(addr, val);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            uri_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void put_db(int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH);
            uri_bytes.push_back(c);
        end
    endfunction

    function automatic void put_keys(int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH || c == CH_QUERY);
            uri_bytes.push_back(c);
        end
    endfunction

    function automatic void put_any(int n);
        repeat (n) uri_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_random_uri();
        int kind;
        kind = $urandom_range(99);
        if (kind < 72) begin
            uri_bytes.push_back(CH_SLASH);
            put_db($urandom_range(1, 10));
            uri_bytes.push_back(CH_SLASH);
            put_keys(($urandom_range(19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24));
            case ($urandom_range(3))
                1: begin
                    uri_bytes.push_back(CH_QUERY);
                    put_any($urandom_range(0, 6));
                end
                2: begin
                    uri_bytes.push_back(CH_SLASH);
                    put_any($urandom_range(0, 6));
                end
                default: ;
            endcase
            if ($urandom_range(9) == 0) begin
                uri_bytes.push_back(CH_NUL);
                put_any($urandom_range(0, 4));
            end
        end else if (kind < 88) begin
            case ($urandom_range(4))
                0: put_keys($urandom_range(1, 8));
                1: begin
                    put_text("//");
                    put_keys($urandom_range(1, 6));
                end
                2: begin
                    uri_bytes.push_back(CH_SLASH);
                    put_db($urandom_range(0, 6));
                end
                3: begin
                    uri_bytes.push_back(CH_SLASH);
                    put_db($urandom_range(1, 4));
                    uri_bytes.push_back(CH_SLASH);
                    if ($urandom_range(1)) begin
                        uri_bytes.push_back($urandom_range(1) ? CH_QUERY : CH_SLASH);
                        put_keys($urandom_range(0, 3));
                    end
                end
                default: begin
                    uri_bytes.push_back(CH_SLASH);
                    put_db($urandom_range(1, 3));
                    if ($urandom_range(1)) begin
                        uri_bytes.push_back(CH_SLASH);
                        put_keys($urandom_range(0, 3));
                    end
                    uri_bytes.push_back(CH_NUL);
                    put_any($urandom_range(0, 4));
                end
            endcase
        end else begin
            put_any($urandom_range(1, 12));
        end
    endfunction

    task automatic run_directed();
        // reset config: rewriting off
        put_text("/db/key");
        send_uri();
        wait_drain();
        set_reg(REG_REWRITE_ENABLE, 16'd1);
        put_text("/db/key");
        send_uri();
        wait_drain();
        set_reg(REG_SHARD_COUNT, 16'd32768);
        put_text("/a/b");
        send_uri();
        put_text("/users/k123?x=1");
        send_uri();
        put_text("/db/key/more");
        send_uri();
        put_text("/x/");
        uri_bytes.push_back(8'hFF);
        uri_bytes.push_back(8'h80);
        uri_bytes.push_back(8'h01);
        send_uri();
        put_text("db/key");
        send_uri();
        put_text("//key");
        send_uri();
        put_text("/dbonly");
        send_uri();
        put_text("/db/");
        send_uri();
        put_text("/db/?q");
        send_uri();
        put_text("/db//");
        send_uri();
        put_text("/db/ke");
        uri_bytes.push_back(CH_NUL);
        put_text("junk/?");
        send_uri();
        uri_bytes.push_back(CH_NUL);
        put_text("/db/key");
        send_uri();
        put_text("/");
        send_uri();
        uri_bytes.push_back(CH_NUL);
        send_uri();
        // database name one byte past the limit
        uri_bytes.push_back(CH_SLASH);
        put_db(MAX_FIELD_DEF + 1);
        put_text("/k");
        send_uri();
        // key runs through the limit; its tail is dropped
        put_text("/d/");
        put_keys(MAX_FIELD_DEF + 6);
        put_text("?z");
        send_uri();
        wait_drain();
        set_reg(REG_SHARD_COUNT, 16'd0);
        put_text("/db/key");
        send_uri();
        put_text("/shop/item42");
        send_uri();
        wait_drain();
        set_reg(REG_SHARD_COUNT, 16'd7);
        put_text("/shop/item42");
        send_uri();
    endtask

    initial begin
        int target;
        board = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cycles = 0;
        uris_sent = 0;
        bytes_sent = 0;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        run_directed();

        target = bytes_sent;
        for (int seg = 0; seg < 6; seg++) begin
            wait_drain();
            case (seg)
                0: begin
                    set_reg(REG_SHARD_COUNT, 16'd32768);
                end
                1: begin
                    set_reg(REG_SHARD_COUNT, 16'($urandom_range(2, 64)));
                end
                2: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 37;
                    set_reg(REG_SHARD_COUNT, 16'd1);
                end
                3: begin
                    set_reg(REG_REWRITE_ENABLE, 16'd0);
                    set_reg(REG_SHARD_COUNT, 16'($urandom_range(1, 32768)));
                end
                4: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_reg(REG_REWRITE_ENABLE, 16'd1);
                    set_reg(REG_SHARD_COUNT, 16'($urandom_range(10001, 32767)));
                end
                default: begin
                    set_reg(REG_SHARD_COUNT, 16'd32767);
                end
            endcase
            target += 50;
            while (bytes_sent < target) begin
                build_random_uri();
                send_uri();
                if ($urandom_range(24) == 0) begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        $display("sent %0d URIs in %0d bytes; checked %0d results over shard counts 0..32768",
                 uris_sent, bytes_sent, board.results_seen);
        $display("rewritten %0d, declined %0d, five-digit shard %0d, mismatches %0d",
                 board.status_hits[STATUS_REWRITTEN], board.status_hits[STATUS_DECLINED],
                 board.status_hits[STATUS_ERROR], board.mismatches);
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
